FILE: sv/bfp_pkg.sv
package bfp_pkg;

    localparam logic [7:0]  SYNC_FIRST  = 8'hB5;
    localparam logic [7:0]  SYNC_SECOND = 8'h62;
    localparam logic [15:0] ERR_MAX     = 16'hFFFF;

    // Parser phases; codes above PH_CHKB are never entered and act as hunting.
    typedef enum logic [3:0] {
        PH_HUNT  = 4'd0,
        PH_SYNC1 = 4'd1,
        PH_SYNC2 = 4'd2,
        PH_CLASS = 4'd3,
        PH_ID    = 4'd4,
        PH_LEN1  = 4'd5,
        PH_BODY  = 4'd6,
        PH_CHKA  = 4'd7,
        PH_CHKB  = 4'd8
    } t_phase;

    typedef enum logic [2:0] {
        EV_NONE     = 3'd0,
        EV_PAYLOAD  = 3'd1,
        EV_GOOD     = 3'd2,
        EV_CHKA_ERR = 3'd3,
        EV_CHKB_ERR = 3'd4
    } t_event;

    typedef struct packed {
        t_event      event_res;
        logic [7:0]  msg_class;
        logic [7:0]  msg_id;
        logic [15:0] frame_length;
        logic [7:0]  payload_byte;
        logic [15:0] payload_index;
        logic        last_payload;
        logic [15:0] error_total;
    } t_result;

endpackage

FILE: sv/bfp_if.sv
interface bfp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface bfp_res_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_res;
    logic [7:0]  msg_class;
    logic [7:0]  msg_id;
    logic [15:0] frame_length;
    logic [7:0]  payload_byte;
    logic [15:0] payload_index;
    logic        last_payload;
    logic [15:0] error_total;

    modport source (
        output valid, output event_res, output msg_class, output msg_id,
        output frame_length, output payload_byte, output payload_index,
        output last_payload, output error_total, input ready
    );
    modport sink (
        input valid, input event_res, input msg_class, input msg_id,
        input frame_length, input payload_byte, input payload_index,
        input last_payload, input error_total, output ready
    );
endinterface

FILE: sv/bfp_in_reg.sv
module bfp_in_reg (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bfp_byte_if.sink   i_rx,
    input  logic       i_advance,
    output logic       o_valid,
    output logic [7:0] o_byte
);

    logic       r_valid;
    logic [7:0] r_byte;
    logic       w_take;

    // The register frees up whenever its content moves on in the same cycle.
    assign i_rx.ready = !r_valid || i_advance;
    assign w_take     = i_rx.valid && i_rx.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_byte <= i_rx.rx_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule

FILE: sv/bfp_core.sv
module bfp_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [7:0]        i_byte,
    output bfp_pkg::t_result  o_res
);

    bfp_pkg::t_phase r_phase, n_phase;
    logic [7:0]      r_class, n_class;
    logic [7:0]      r_id, n_id;
    logic [15:0]     r_length, n_length;
    logic [15:0]     r_count, n_count;
    logic [7:0]      r_sum_a, n_sum_a;
    logic [7:0]      r_sum_b, n_sum_b;
    logic [15:0]     r_bad, n_bad;

    logic [7:0]      w_fold_a;
    logic [7:0]      w_fold_b;
    logic [15:0]     w_count_inc;
    logic [15:0]     w_bad_inc;

    assign w_fold_a    = r_sum_a + i_byte;
    assign w_fold_b    = r_sum_b + w_fold_a;
    assign w_count_inc = r_count + 16'd1;
    assign w_bad_inc   = (r_bad == bfp_pkg::ERR_MAX) ? r_bad : r_bad + 16'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= bfp_pkg::PH_HUNT;
            r_class  <= '0;
            r_id     <= '0;
            r_length <= '0;
            r_count  <= '0;
            r_sum_a  <= '0;
            r_sum_b  <= '0;
            r_bad    <= '0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_class  <= n_class;
            r_id     <= n_id;
            r_length <= n_length;
            r_count  <= n_count;
            r_sum_a  <= n_sum_a;
            r_sum_b  <= n_sum_b;
            r_bad    <= n_bad;
        end
    end

    always_comb begin
        n_phase  = r_phase;
        n_class  = r_class;
        n_id     = r_id;
        n_length = r_length;
        n_count  = r_count;
        n_sum_a  = r_sum_a;
        n_sum_b  = r_sum_b;
        n_bad    = r_bad;

        o_res.event_res     = bfp_pkg::EV_NONE;
        o_res.payload_byte  = '0;
        o_res.payload_index = '0;
        o_res.last_payload  = 1'b0;

        case (r_phase)
            bfp_pkg::PH_SYNC1: begin
                if (i_byte == bfp_pkg::SYNC_SECOND) begin
                    n_phase = bfp_pkg::PH_SYNC2;
                    n_sum_a = '0;
                    n_sum_b = '0;
                end else begin
                    n_phase = bfp_pkg::PH_HUNT;
                end
            end
            bfp_pkg::PH_SYNC2: begin
                n_class = i_byte;
                n_sum_a = w_fold_a;
                n_sum_b = w_fold_b;
                n_phase = bfp_pkg::PH_CLASS;
            end
            bfp_pkg::PH_CLASS: begin
                n_id    = i_byte;
                n_sum_a = w_fold_a;
                n_sum_b = w_fold_b;
                n_phase = bfp_pkg::PH_ID;
            end
            bfp_pkg::PH_ID: begin
                n_length = {8'h00, i_byte};
                n_sum_a  = w_fold_a;
                n_sum_b  = w_fold_b;
                n_phase  = bfp_pkg::PH_LEN1;
            end
            bfp_pkg::PH_LEN1: begin
                n_length = {i_byte, r_length[7:0]};
                n_sum_a  = w_fold_a;
                n_sum_b  = w_fold_b;
                n_count  = '0;
                // An empty payload goes straight to the first check byte.
                n_phase  = (n_length == 16'd0) ? bfp_pkg::PH_CHKA : bfp_pkg::PH_BODY;
            end
            bfp_pkg::PH_BODY: begin
                n_sum_a             = w_fold_a;
                n_sum_b             = w_fold_b;
                n_count             = w_count_inc;
                o_res.event_res     = bfp_pkg::EV_PAYLOAD;
                o_res.payload_byte  = i_byte;
                o_res.payload_index = r_count;
                if (w_count_inc >= r_length) begin
                    o_res.last_payload = 1'b1;
                    n_phase            = bfp_pkg::PH_CHKA;
                end
            end
            bfp_pkg::PH_CHKA: begin
                if (i_byte == r_sum_a) begin
                    n_phase = bfp_pkg::PH_CHKB;
                end else begin
                    o_res.event_res = bfp_pkg::EV_CHKA_ERR;
                    n_bad           = w_bad_inc;
                    n_phase         = bfp_pkg::PH_HUNT;
                end
            end
            bfp_pkg::PH_CHKB: begin
                if (i_byte == r_sum_b) begin
                    o_res.event_res = bfp_pkg::EV_GOOD;
                end else begin
                    o_res.event_res = bfp_pkg::EV_CHKB_ERR;
                    n_bad           = w_bad_inc;
                end
                n_phase = bfp_pkg::PH_HUNT;
            end
            default: begin
                n_phase = (i_byte == bfp_pkg::SYNC_FIRST) ? bfp_pkg::PH_SYNC1
                                                          : bfp_pkg::PH_HUNT;
            end
        endcase

        o_res.msg_class    = n_class;
        o_res.msg_id       = n_id;
        o_res.frame_length = n_length;
        o_res.error_total  = n_bad;
    end

`ifndef SYNTH
    a_err_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> r_bad >= $past(r_bad))
        else $error("error count went down");

    a_hold_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> $stable(r_phase) && $stable(r_sum_a) && $stable(r_sum_b))
        else $error("parser state moved without a byte");

    a_chkb_returns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && r_phase == bfp_pkg::PH_CHKB |=> r_phase == bfp_pkg::PH_HUNT)
        else $error("parser did not return to hunting after check B");

    a_last_is_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.last_payload |-> o_res.event_res == bfp_pkg::EV_PAYLOAD
                               && r_phase == bfp_pkg::PH_BODY)
        else $error("last flag outside a payload byte");
`endif

endmodule

FILE: sv/bfp_out_reg.sv
module bfp_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  bfp_pkg::t_result i_res,
    output logic             o_advance,
    bfp_res_if.source        o_res
);

    logic             r_valid;
    bfp_pkg::t_result r_res;

    // The result register can take a new result when empty or being drained.
    assign o_advance = !r_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance && i_valid) begin
            r_res <= i_res;
        end
    end

    assign o_res.valid         = r_valid;
    assign o_res.event_res     = r_res.event_res;
    assign o_res.msg_class     = r_res.msg_class;
    assign o_res.msg_id        = r_res.msg_id;
    assign o_res.frame_length  = r_res.frame_length;
    assign o_res.payload_byte  = r_res.payload_byte;
    assign o_res.payload_index = r_res.payload_index;
    assign o_res.last_payload  = r_res.last_payload;
    assign o_res.error_total   = r_res.error_total;

endmodule

FILE: sv/binary_frame_parser_fletcher8.sv
// Channel   Direction  Payload
// i_rx      in         rx_byte
// o_res     out        event_res, msg_class, msg_id, frame_length,
//                      payload_byte, payload_index, last_payload, error_total
//
// One byte is accepted per cycle while o_res is not stalled; each byte yields exactly one result.
// Each byte passes through an input register, then the parser state update
// and Fletcher sums, which write the result register.
// Reset is synchronous and active low and returns the parser to hunting.
// A stall on o_res holds the result register, then the input register, then i_rx.

module binary_frame_parser_fletcher8 (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bfp_byte_if.sink  i_rx,
    bfp_res_if.source o_res
);

    logic             w_in_valid;
    logic [7:0]       w_in_byte;
    logic             w_advance;
    bfp_pkg::t_result w_res;

    bfp_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rx      (i_rx),
        .i_advance (w_advance),
        .o_valid   (w_in_valid),
        .o_byte    (w_in_byte)
    );

    bfp_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_in_valid && w_advance),
        .i_byte  (w_in_byte),
        .o_res   (w_res)
    );

    bfp_out_reg u_out_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (w_in_valid),
        .i_res     (w_res),
        .o_advance (w_advance),
        .o_res     (o_res)
    );

endmodule

FILE: verif/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 300;
    localparam int RANDOM_BYTES   = 1450;
    localparam int DRAIN_CYCLES   = 8;

    typedef enum logic [1:0] {
        CHK_OK,
        CHK_BAD_A,
        CHK_BAD_B
    } t_chk_mode;

    // Tracks the parser state byte by byte and holds the results it should produce.
    class frame_scoreboard;
        bfp_pkg::t_phase  phase;
        logic [7:0]       cls;
        logic [7:0]       id;
        logic [15:0]      len;
        logic [15:0]      count;
        logic [7:0]       sum_a;
        logic [7:0]       sum_b;
        logic [15:0]      bad_frames;
        bfp_pkg::t_result expected_q[$];
        int               mismatches;
        int               bytes_seen;
        int               good_frames;
        int               payload_bytes;
        int               check_errors;

        function new();
            phase      = bfp_pkg::PH_HUNT;
            cls        = '0;
            id         = '0;
            len        = '0;
            count      = '0;
            sum_a      = '0;
            sum_b      = '0;
            bad_frames = '0;
            mismatches = 0;
        endfunction

        function void fold(logic [7:0] v);
            sum_a = sum_a + v;
            sum_b = sum_b + sum_a;
        endfunction

        function void count_error();
            check_errors++;
            if (bad_frames != bfp_pkg::ERR_MAX) begin
                bad_frames = bad_frames + 16'd1;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_byte(logic [7:0] b);
            bfp_pkg::t_result r;
            r = '0;
            bytes_seen++;
            case (phase)
                bfp_pkg::PH_SYNC1: begin
                    if (b == bfp_pkg::SYNC_SECOND) begin
                        phase = bfp_pkg::PH_SYNC2;
                        sum_a = '0;
                        sum_b = '0;
                    end else begin
                        phase = bfp_pkg::PH_HUNT;
                    end
                end
                bfp_pkg::PH_SYNC2: begin
                    cls = b;
                    fold(b);
                    phase = bfp_pkg::PH_CLASS;
                end
                bfp_pkg::PH_CLASS: begin
                    id = b;
                    fold(b);
                    phase = bfp_pkg::PH_ID;
                end
                bfp_pkg::PH_ID: begin
                    len = {8'h00, b};
                    fold(b);
                    phase = bfp_pkg::PH_LEN1;
                end
                bfp_pkg::PH_LEN1: begin
                    len[15:8] = b;
                    fold(b);
                    count = '0;
                    phase = (len == 16'd0) ? bfp_pkg::PH_CHKA : bfp_pkg::PH_BODY;
                end
                bfp_pkg::PH_BODY: begin
                    fold(b);
                    r.event_res     = bfp_pkg::EV_PAYLOAD;
                    r.payload_byte  = b;
                    r.payload_index = count;
                    payload_bytes++;
                    count = count + 16'd1;
                    if (count >= len) begin
                        r.last_payload = 1'b1;
                        phase = bfp_pkg::PH_CHKA;
                    end
                end
                bfp_pkg::PH_CHKA: begin
                    if (b == sum_a) begin
                        phase = bfp_pkg::PH_CHKB;
                    end else begin
                        r.event_res = bfp_pkg::EV_CHKA_ERR;
                        count_error();
                        phase = bfp_pkg::PH_HUNT;
                    end
                end
                bfp_pkg::PH_CHKB: begin
                    if (b == sum_b) begin
                        r.event_res = bfp_pkg::EV_GOOD;
                        good_frames++;
                    end else begin
                        r.event_res = bfp_pkg::EV_CHKB_ERR;
                        count_error();
                    end
                    phase = bfp_pkg::PH_HUNT;
                end
                default: begin
                    phase = (b == bfp_pkg::SYNC_FIRST) ? bfp_pkg::PH_SYNC1
                                                       : bfp_pkg::PH_HUNT;
                end
            endcase
            r.msg_class    = cls;
            r.msg_id       = id;
            r.frame_length = len;
            r.error_total  = bad_frames;
            expected_q.push_back(r);
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                $display("%0t: mismatch in %s, expected 'h%0h, actual 'h%0h",
                         $time, name, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(bfp_pkg::t_result got);
            bfp_pkg::t_result want;
            if (expected_q.size() == 0) begin
                $display("%0t: result with no byte behind it, expected none, actual 'h%0h",
                         $time, got);
                mismatches++;
                return;
            end
            want = expected_q.pop_front();
            compare_field("event_res", 16'(want.event_res), 16'(got.event_res));
            compare_field("msg_class", 16'(want.msg_class), 16'(got.msg_class));
            compare_field("msg_id", 16'(want.msg_id), 16'(got.msg_id));
            compare_field("frame_length", want.frame_length, got.frame_length);
            compare_field("payload_byte", 16'(want.payload_byte), 16'(got.payload_byte));
            compare_field("payload_index", want.payload_index, got.payload_index);
            compare_field("last_payload", 16'(want.last_payload), 16'(got.last_payload));
            compare_field("error_total", want.error_total, got.error_total);
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    bfp_byte_if rx_if ();
    bfp_res_if  res_if ();

    binary_frame_parser_fletcher8 uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_if.sink),
        .o_res   (res_if.source)
    );

    frame_scoreboard sb = new();

    int tx_max_gap   = 0;
    int rx_max_stall = 0;
    bit hold_req     = 1'b0;
    int frame_bytes  = 0;
    int idle_cycles  = 0;

    always #1 i_clk = ~i_clk;

    // A gap of zero keeps valid high so the next byte follows straight on.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = $urandom_range(0, tx_max_gap);
        if (gap > 0) begin
            rx_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        do @(posedge i_clk); while (rx_if.ready !== 1'b1);
        sb.note_byte(b);
    endtask

    task automatic send_summed(input logic [7:0] v, inout logic [7:0] ca,
                               inout logic [7:0] cb);
        send_byte(v);
        ca = ca + v;
        cb = cb + ca;
    endtask

    task automatic send_frame(input logic [7:0] cls, input logic [7:0] id,
                              input logic [15:0] len, input t_chk_mode mode);
        logic [7:0] ca;
        logic [7:0] cb;
        ca = '0;
        cb = '0;
        send_byte(bfp_pkg::SYNC_FIRST);
        send_byte(bfp_pkg::SYNC_SECOND);
        send_summed(cls, ca, cb);
        send_summed(id, ca, cb);
        send_summed(len[7:0], ca, cb);
        send_summed(len[15:8], ca, cb);
        for (int i = 0; i < len; i++) begin
            send_summed(8'($urandom), ca, cb);
        end
        send_byte((mode == CHK_BAD_A) ? ca + 8'($urandom_range(1, 255)) : ca);
        if (mode != CHK_BAD_A) begin
            send_byte((mode == CHK_BAD_B) ? cb + 8'($urandom_range(1, 255)) : cb);
        end
        frame_bytes += int'(len) + 8;
    endtask

    // Result side: random stalls per transfer, plus one long hold-off on request.
    initial begin
        int               stall;
        bfp_pkg::t_result got;
        res_if.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (hold_req) begin
                stall    = HOLD_CYCLES;
                hold_req = 1'b0;
            end else begin
                stall = $urandom_range(0, rx_max_stall);
            end
            if (stall > 0) begin
                res_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
            do @(posedge i_clk); while (res_if.valid !== 1'b1);
            got.event_res     = bfp_pkg::t_event'(res_if.event_res);
            got.msg_class     = res_if.msg_class;
            got.msg_id        = res_if.msg_id;
            got.frame_length  = res_if.frame_length;
            got.payload_byte  = res_if.payload_byte;
            got.payload_index = res_if.payload_index;
            got.last_payload  = res_if.last_payload;
            got.error_total   = res_if.error_total;
            sb.check_result(got);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
                $display("tb: failure");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        int          r;
        int          frame_count;
        logic [7:0]  v;
        logic [15:0] len;
        t_chk_mode   mode;

        i_rst_n       <= 1'b0;
        rx_if.valid   <= 1'b0;
        rx_if.rx_byte <= 8'h00;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: byte extremes while hunting, a bad second sync byte that is
        // itself a first sync byte, a zero-length frame, and both check errors.
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(bfp_pkg::SYNC_FIRST);
        send_byte(bfp_pkg::SYNC_FIRST);
        send_byte(bfp_pkg::SYNC_SECOND);
        send_frame(8'hFF, 8'h00, 16'd0, CHK_OK);
        send_frame(8'h00, 8'hFF, 16'd1, CHK_BAD_B);
        send_frame(8'h80, 8'h7F, 16'd0, CHK_BAD_A);

        frame_bytes = 0;
        frame_count = 0;
        while (frame_bytes < RANDOM_BYTES) begin
            if (frame_count % 12 == 0) begin
                case ($urandom_range(0, 3))
                    0: begin tx_max_gap = 0; rx_max_stall = 0; end
                    1: begin tx_max_gap = 5; rx_max_stall = 5; end
                    2: begin tx_max_gap = 0; rx_max_stall = 5; end
                    default: begin tx_max_gap = 5; rx_max_stall = 0; end
                endcase
            end
            if (frame_count == 40) begin
                hold_req = 1'b1;
            end
            r = $urandom_range(0, 99);
            if (r < 85) begin
                mode = (r < 60) ? CHK_OK : (r < 73) ? CHK_BAD_A : CHK_BAD_B;
                len  = ($urandom_range(0, 24) == 0) ? 16'($urandom_range(16, 300))
                                                     : 16'($urandom_range(0, 12));
                send_frame(8'($urandom), 8'($urandom), len, mode);
            end else if (r < 92) begin
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
            end else begin
                send_byte(bfp_pkg::SYNC_FIRST);
                do v = 8'($urandom); while (v == bfp_pkg::SYNC_SECOND);
                send_byte($urandom_range(0, 1) ? bfp_pkg::SYNC_FIRST : v);
            end
            frame_count++;
        end

        // A short back-to-back run of bad frames, then a good frame.
        tx_max_gap   = 0;
        rx_max_stall = 0;
        repeat (4) send_frame(8'($urandom), 8'($urandom), 16'd0, CHK_BAD_A);
        repeat (3) send_frame(8'($urandom), 8'($urandom), 16'd2, CHK_BAD_B);
        send_frame(8'($urandom), 8'($urandom), 16'd4, CHK_OK);

        rx_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("tb: %0d bytes parsed: %0d good frames, %0d payload bytes, %0d check errors",
                 sb.bytes_seen, sb.good_frames, sb.payload_bytes, sb.check_errors);
        $display("tb: error count ended at 'h%0h, with random idling and one long output hold",
                 sb.bad_frames);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule

FILE: files.f
sv/bfp_pkg.sv
sv/bfp_if.sv
sv/bfp_in_reg.sv
sv/bfp_core.sv
sv/bfp_out_reg.sv
sv/binary_frame_parser_fletcher8.sv
verif/tb_top.sv
